// ----- hdl/cct_pkg.sv -----
package cct_pkg;

    localparam int MONTH_W = 4;
    localparam int DAY_W   = 5;
    localparam int YEAR_W  = 16;
    localparam int HOUR_W  = 5;
    localparam int MIN_W   = 6;
    localparam int SEC_W   = 6;
    localparam int FRAC_W  = 10;

    localparam logic [SEC_W-1:0]  SEC_TOP  = SEC_W'(59);
    localparam logic [MIN_W-1:0]  MIN_TOP  = MIN_W'(59);
    localparam logic [HOUR_W-1:0] HOUR_TOP = HOUR_W'(23);

    localparam logic [MONTH_W-1:0] MONTH_JAN = MONTH_W'(1);
    localparam logic [MONTH_W-1:0] MONTH_FEB = MONTH_W'(2);
    localparam logic [MONTH_W-1:0] MONTH_MAR = MONTH_W'(3);
    localparam logic [MONTH_W-1:0] MONTH_MAY = MONTH_W'(5);
    localparam logic [MONTH_W-1:0] MONTH_JUL = MONTH_W'(7);
    localparam logic [MONTH_W-1:0] MONTH_AUG = MONTH_W'(8);
    localparam logic [MONTH_W-1:0] MONTH_OCT = MONTH_W'(10);
    localparam logic [MONTH_W-1:0] MONTH_DEC = MONTH_W'(12);

    localparam logic [DAY_W-1:0] DAY_FIRST = DAY_W'(1);
    localparam logic [DAY_W-1:0] DAY_28    = DAY_W'(28);
    localparam logic [DAY_W-1:0] DAY_29    = DAY_W'(29);
    localparam logic [DAY_W-1:0] DAY_30    = DAY_W'(30);
    localparam logic [DAY_W-1:0] DAY_31    = DAY_W'(31);

    // Multiplicative inverse of 25 modulo 2**16 and the largest product that
    // marks an exact multiple of 25.
    localparam logic [YEAR_W-1:0] INV25     = YEAR_W'(23593);
    localparam logic [YEAR_W-1:0] DIV25_MAX = YEAR_W'(65535 / 25);

    // Register map, index of each start register.
    localparam int REG_IDX_W = 3;
    localparam logic [REG_IDX_W-1:0] REG_START_MONTH    = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_START_DAY      = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_START_YEAR     = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_START_HOUR     = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_START_MINUTE   = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_START_SECOND   = 3'd5;
    localparam logic [REG_IDX_W-1:0] REG_START_FRACTION = 3'd6;

    typedef struct packed {
        logic [HOUR_W-1:0] hour;
        logic [MIN_W-1:0]  minute;
        logic [SEC_W-1:0]  second;
        logic [FRAC_W-1:0] fraction;
    } t_time;

    typedef struct packed {
        logic [MONTH_W-1:0] month;
        logic [DAY_W-1:0]   day;
        logic [YEAR_W-1:0]  year;
    } t_date;

    // Divisible by 4 and not by 100, or divisible by 400. Divisibility by 25
    // uses the modular-inverse test, so one 16x16 product suffices.
    function automatic logic is_leap(input logic [YEAR_W-1:0] year);
        logic [2*YEAR_W-1:0] prod;
        logic                div25;
        prod  = year * INV25;
        div25 = (prod[YEAR_W-1:0] <= DIV25_MAX);
        return (year[1:0] == 2'b00) && (!div25 || (year[3:2] == 2'b00));
    endfunction

    function automatic logic [DAY_W-1:0] month_end(input logic [MONTH_W-1:0] month,
                                                   input logic               leap);
        logic [DAY_W-1:0] last;
        if (month == MONTH_FEB) begin
            last = leap ? DAY_29 : DAY_28;
        end else if (month == MONTH_JAN || month == MONTH_MAR || month == MONTH_MAY ||
                     month == MONTH_JUL || month == MONTH_AUG || month == MONTH_OCT ||
                     month == MONTH_DEC) begin
            last = DAY_31;
        end else begin
            last = DAY_30;
        end
        return last;
    endfunction

endpackage

// ----- hdl/cct_time.sv -----
module cct_time #(
    parameter int TICKS_PER_SECOND = 1000
) (
    input  cct_pkg::t_time i_cur,
    input  logic           i_tick,
    output cct_pkg::t_time o_next,
    output logic           o_wrap
);
    import cct_pkg::*;

    localparam logic [FRAC_W-1:0] FRAC_TOP = FRAC_W'(TICKS_PER_SECOND - 1);

    // Each counter advances only below its top; at or above it, it clears
    // and carries into the next one.
    always_comb begin
        o_next = i_cur;
        o_wrap = 1'b0;
        if (i_tick) begin
            if (i_cur.fraction < FRAC_TOP) begin
                o_next.fraction = i_cur.fraction + 1'b1;
            end else begin
                o_next.fraction = '0;
                if (i_cur.second < SEC_TOP) begin
                    o_next.second = i_cur.second + 1'b1;
                end else begin
                    o_next.second = '0;
                    if (i_cur.minute < MIN_TOP) begin
                        o_next.minute = i_cur.minute + 1'b1;
                    end else begin
                        o_next.minute = '0;
                        if (i_cur.hour < HOUR_TOP) begin
                            o_next.hour = i_cur.hour + 1'b1;
                        end else begin
                            o_next.hour = '0;
                            o_wrap      = 1'b1;
                        end
                    end
                end
            end
        end
    end

endmodule

// ----- hdl/cct_date.sv -----
module cct_date (
    input  cct_pkg::t_date i_cur,
    input  logic           i_advance,
    output cct_pkg::t_date o_next
);
    import cct_pkg::*;

    logic             leap;
    logic [DAY_W-1:0] last_day;

    assign leap     = is_leap(i_cur.year);
    assign last_day = month_end(i_cur.month, leap);

    // The month end is matched by equality only, so a day beyond it keeps
    // counting and wraps in its own width.
    always_comb begin
        o_next = i_cur;
        if (i_advance) begin
            if (i_cur.month == MONTH_DEC && i_cur.day == DAY_31) begin
                o_next.month = MONTH_JAN;
                o_next.day   = DAY_FIRST;
                o_next.year  = i_cur.year + 1'b1;
            end else if (i_cur.day == last_day) begin
                o_next.day   = DAY_FIRST;
                o_next.month = i_cur.month + 1'b1;
            end else begin
                o_next.day   = i_cur.day + 1'b1;
            end
        end
    end

endmodule

// ----- hdl/calendar_clock_tick_unit.sv -----
// Real-time clock with Gregorian calendar. Each item on the slave stream is
// one sub-second tick (bit 0 set) or an idle item (bit 0 clear); every item
// yields exactly one result item carrying the date and time after it, plus a
// flag that is set when that tick crossed midnight. The start date and time
// are written over the APB port (month, day, year, hour, minute, second,
// fraction at byte offsets 0x00..0x18); any such write arms a reload, and the
// next tick loads the start values and then advances them. One item is taken
// per clock cycle; the result appears in the cycle after acceptance in an output
// register, and a new item is accepted whenever that register is empty or is
// being drained in the same cycle. The longest path is the leap-year product
// followed by the month-end compare in the date unit.
module calendar_clock_tick_unit #(
    parameter int TICKS_PER_SECOND = 1000
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [7:0]  i_s_tdata,   // [0] tick_pulse, [7:1] zero
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    // [3:0] cur_month, [8:4] cur_day, [24:9] cur_year, [29:25] cur_hour,
    // [35:30] cur_minute, [41:36] cur_second, [51:42] cur_fraction,
    // [52] day_rolled, [55:53] zero
    output logic [55:0] o_m_tdata,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import cct_pkg::*;

    t_time r_time, r_start_time;
    t_date r_date, r_start_date;
    logic  r_reload_pending;
    logic  r_m_valid;
    logic [55:0] r_m_data;

    t_time cur_time, n_time;
    t_date cur_date, n_date;
    logic  tick, use_start, wrap, s_accept, cfg_write;
    logic [REG_IDX_W-1:0] reg_idx;

    assign pready    = 1'b1;
    assign reg_idx   = paddr[4:2];
    assign cfg_write = psel && penable && pwrite && pready;

    assign s_accept   = i_s_tvalid && o_s_tready;
    assign o_s_tready = !r_m_valid || i_m_tready;
    assign tick       = i_s_tdata[0];
    assign use_start  = r_reload_pending && tick;

    assign cur_time = use_start ? r_start_time : r_time;
    assign cur_date = use_start ? r_start_date : r_date;

    cct_time #(
        .TICKS_PER_SECOND(TICKS_PER_SECOND)
    ) u_time (
        .i_cur  (cur_time),
        .i_tick (tick),
        .o_next (n_time),
        .o_wrap (wrap)
    );

    cct_date u_date (
        .i_cur     (cur_date),
        .i_advance (wrap),
        .o_next    (n_date)
    );

    // Start registers and reload flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_date.month  <= MONTH_JAN;
            r_start_date.day    <= DAY_FIRST;
            r_start_date.year   <= YEAR_W'(2000);
            r_start_time        <= '0;
            r_reload_pending    <= 1'b1;
        end else if (cfg_write) begin
            // A write past the last register changes nothing and arms no reload.
            if (reg_idx <= REG_START_FRACTION) begin
                r_reload_pending <= 1'b1;
            end
            unique case (reg_idx)
                REG_START_MONTH:    r_start_date.month    <= pwdata[MONTH_W-1:0];
                REG_START_DAY:      r_start_date.day      <= pwdata[DAY_W-1:0];
                REG_START_YEAR:     r_start_date.year     <= pwdata[YEAR_W-1:0];
                REG_START_HOUR:     r_start_time.hour     <= pwdata[HOUR_W-1:0];
                REG_START_MINUTE:   r_start_time.minute   <= pwdata[MIN_W-1:0];
                REG_START_SECOND:   r_start_time.second   <= pwdata[SEC_W-1:0];
                REG_START_FRACTION: r_start_time.fraction <= pwdata[FRAC_W-1:0];
                default:            ;
            endcase
        end else if (s_accept && tick) begin
            r_reload_pending <= 1'b0;
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_START_MONTH:    prdata = 32'(r_start_date.month);
            REG_START_DAY:      prdata = 32'(r_start_date.day);
            REG_START_YEAR:     prdata = 32'(r_start_date.year);
            REG_START_HOUR:     prdata = 32'(r_start_time.hour);
            REG_START_MINUTE:   prdata = 32'(r_start_time.minute);
            REG_START_SECOND:   prdata = 32'(r_start_time.second);
            REG_START_FRACTION: prdata = 32'(r_start_time.fraction);
            default:            prdata = '0;
        endcase
    end

    // Running counters.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_time       <= '0;
            r_date.month <= MONTH_JAN;
            r_date.day   <= DAY_FIRST;
            r_date.year  <= YEAR_W'(2000);
        end else if (s_accept) begin
            r_time <= n_time;
            r_date <= n_date;
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (s_accept) begin
            r_m_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_m_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_accept) begin
            r_m_data <= {3'b000, wrap, n_time.fraction, n_time.second, n_time.minute,
                         n_time.hour, n_date.year, n_date.day, n_date.month};
        end
    end

    assign o_m_tvalid = r_m_valid;
    assign o_m_tdata  = r_m_data;

    a_accept_fills_output: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_accept |=> r_m_valid)
        else $error("accepted item produced no result");

    a_tick_clears_reload: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_accept && tick && !cfg_write) |=> !r_reload_pending)
        else $error("reload still pending after a tick");

    a_idle_no_roll: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_accept && !tick) |=> !r_m_data[52])
        else $error("day rollover reported for an idle item");

    a_roll_at_midnight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_m_valid && r_m_data[52]) |-> (r_m_data[51:25] == '0))
        else $error("day rollover reported away from midnight");

    a_idle_holds_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_accept && !tick) |=> (r_time == $past(r_time)) && (r_date == $past(r_date)))
        else $error("counters moved on an idle item");

endmodule
